@@ design/rpse_pkg.sv @@
package rpse_pkg;

	// Strip geometry and channel codes
	localparam int MAX_PIXELS = 256;
	localparam logic FUNC_COLOR = 1'b0;
	localparam logic FUNC_WHITE = 1'b1;

	// Strip bit to SPI nibble codes
	localparam logic [3:0] NIB_ZERO = 4'h8;
	localparam logic [3:0] NIB_ONE  = 4'hC;

	// Fixed-point constants of the colour path
	localparam logic [23:0] BAL_DEN      = 24'd65025;       // 255 * 255
	localparam logic [41:0] ROUND_BIAS   = 42'd2130739200;  // 32768 * 65025
	localparam logic [16:0] RECIP_MUL    = 17'd66051;       // floor(2^32 / 65025)
	localparam logic [6:0]  SHARE_MAX    = 7'd100;
	localparam logic [12:0] DIV100_MUL   = 13'd5243;        // 2^19 / 100, rounded up
	localparam logic [25:0] WHITE_BIAS   = 26'd32768;

	// Pixel queue between front and back
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Register map (index = paddr[4:2])
	localparam logic [2:0] REG_STRIP_LENGTH   = 3'd0;
	localparam logic [2:0] REG_FOUR_CHANNEL   = 3'd1;
	localparam logic [2:0] REG_BRIGHTNESS_CAP = 3'd2;
	localparam logic [2:0] REG_WHITE_SHARE    = 3'd3;
	localparam logic [2:0] REG_BALANCE_RED    = 3'd4;
	localparam logic [2:0] REG_BALANCE_GREEN  = 3'd5;
	localparam logic [2:0] REG_BALANCE_BLUE   = 3'd6;

	localparam logic [8:0] RST_STRIP_LENGTH   = 9'd0;
	localparam logic       RST_FOUR_CHANNEL   = 1'b1;
	localparam logic [7:0] RST_BRIGHTNESS_CAP = 8'd120;
	localparam logic [6:0] RST_WHITE_SHARE    = 7'd45;
	localparam logic [7:0] RST_BALANCE        = 8'd255;

	typedef struct packed {
		logic [8:0] strip_length;
		logic       four_channel;
		logic [7:0] brightness_cap;
		logic [6:0] white_share;
		logic [7:0] balance_red;
		logic [7:0] balance_green;
		logic [7:0] balance_blue;
	} cfg_t;

	// One rendered pixel: channels in wire order G,R,B,W
	typedef struct packed {
		logic            four;
		logic [11:0]     base_off;
		logic [3:0][7:0] ch;
	} pix_t;

	typedef struct packed {
		logic        func;
		logic        four;
		logic [11:0] base_off;
	} meta_t;

	// Gamma 2.6 curve entry, Q1.16, round half up: the largest q with
	// (2q - 1)^5 * 2^(13 * level_bits) <= idx^13 * 2^85, in wide integers
	function automatic logic [16:0] gamma_entry(input int idx, input int level_bits);
		logic [319:0] lhs;
		logic [319:0] rhs;
		int           lo;
		int           hi;
		int           mid;
		lo  = 0;
		hi  = 65536;
		rhs = 320'd1;
		for (int k = 0; k < 13; k++) begin
			rhs = rhs * 320'(idx);
		end
		rhs = rhs << 85;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = 320'd1;
			for (int k = 0; k < 5; k++) begin
				lhs = lhs * 320'(2 * mid - 1);
			end
			lhs = lhs << (13 * level_bits);
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return 17'(lo);
	endfunction

	function automatic logic [7:0] spi_pair(input logic hi, input logic lo);
		return {(hi ? NIB_ONE : NIB_ZERO), (lo ? NIB_ONE : NIB_ZERO)};
	endfunction

endpackage

@@ design/rgbw_pixel_spi_encoder_core.sv @@
// RGBW pixel to SPI bit-pattern encoder.
//
// Input stream (s_t*): one transaction per pixel request. s_tuser selects a
// colour pixel (0) or a white-die-only pixel (1). Requests whose index is at or
// beyond strip_length are taken and produce nothing.
// Output stream (m_t*): 12 (RGB strip) or 16 (RGBW strip) transactions per
// pixel, each one SPI byte with its frame buffer offset; m_tlast marks the
// final byte of the pixel.
// Configuration: APB, register i at byte address 4*i, pready tied high.
// Path: an accepted request passes through an 8-stage colour pipeline, the
// pixel queue and the output register before its first byte goes out.
// Throughput: one byte per cycle while pixels are queued and m_tready is high,
// from the byte serializer in the back end; up to 8 pixels can be in flight.
// Reset clears the pipeline, the queue and the output register and loads the
// register defaults. When the receiver stalls, the output byte holds, the
// queue fills, and s_tready drops once 8 pixels are waiting or in flight.
module rgbw_pixel_spi_encoder_core #(
	parameter int LEVEL_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pixel_index[7:0], red[15:8], green[23:16],
	                               // blue[31:24], level[42:32], zero fill
	input  logic        s_tuser,   // func
	// SPI byte stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // spi_byte[7:0], byte_offset[19:8], zero fill
	output logic        m_tlast
);
	import rpse_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic push_valid;
	pix_t push_data;
	logic pop;
	logic head_valid;
	pix_t head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register file: write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_length   <= RST_STRIP_LENGTH;
			cfg_q.four_channel   <= RST_FOUR_CHANNEL;
			cfg_q.brightness_cap <= RST_BRIGHTNESS_CAP;
			cfg_q.white_share    <= RST_WHITE_SHARE;
			cfg_q.balance_red    <= RST_BALANCE;
			cfg_q.balance_green  <= RST_BALANCE;
			cfg_q.balance_blue   <= RST_BALANCE;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_STRIP_LENGTH:   cfg_q.strip_length   <= pwdata[8:0];
				REG_FOUR_CHANNEL:   cfg_q.four_channel   <= pwdata[0];
				REG_BRIGHTNESS_CAP: cfg_q.brightness_cap <= pwdata[7:0];
				REG_WHITE_SHARE:    cfg_q.white_share    <= pwdata[6:0];
				REG_BALANCE_RED:    cfg_q.balance_red    <= pwdata[7:0];
				REG_BALANCE_GREEN:  cfg_q.balance_green  <= pwdata[7:0];
				REG_BALANCE_BLUE:   cfg_q.balance_blue   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (paddr[4:2])
			REG_STRIP_LENGTH:   prdata = 32'(cfg_q.strip_length);
			REG_FOUR_CHANNEL:   prdata = 32'(cfg_q.four_channel);
			REG_BRIGHTNESS_CAP: prdata = 32'(cfg_q.brightness_cap);
			REG_WHITE_SHARE:    prdata = 32'(cfg_q.white_share);
			REG_BALANCE_RED:    prdata = 32'(cfg_q.balance_red);
			REG_BALANCE_GREEN:  prdata = 32'(cfg_q.balance_green);
			REG_BALANCE_BLUE:   prdata = 32'(cfg_q.balance_blue);
			default:            prdata = '0;
		endcase
	end

	// Front: classify requests, run gamma and colour math
	rpse_front #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.pop        (pop),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Queue of rendered pixels decouples the math from the byte stream
	rpse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: serialize each pixel into SPI bytes
	rpse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

@@ design/rpse_front.sv @@
module rpse_front #(
	parameter int LEVEL_BITS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rpse_pkg::cfg_t cfg,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [47:0]    s_tdata,
	input  logic           s_tuser,
	input  logic           pop,
	output logic           push_valid,
	output rpse_pkg::pix_t push_data
);
	import rpse_pkg::*;

	localparam int FULL      = 1 << LEVEL_BITS;
	localparam int ROM_DEPTH = FULL + 1;
	localparam int LVW       = LEVEL_BITS + 1;

	logic [16:0] gamma_rom [ROM_DEPTH];

	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		assign gamma_rom[i] = gamma_entry(i, LEVEL_BITS);
	end

	logic [QCW-1:0] inflight_q;
	logic           accept;
	logic           on_strip;
	logic [10:0]    len;
	logic [16:0]    level_x;
	logic [LVW-1:0] lv;
	logic [11:0]    off;
	logic [2:0][7:0] bal;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;
	logic [2:0][7:0]  base_s1;
	logic [16:0]      gq_s1;
	logic [2:0][24:0] rg_s2;
	logic [2:0][15:0] bb_s2;
	logic [24:0]      wg_s2;
	logic [2:0][40:0] p_s3;
	logic [7:0]       white_s3, white_s4, white_s5, white_s6, white_s7;
	logic [2:0][23:0] t_s4, t_s5;
	logic [2:0][7:0]  q_s5, c_s6, c_s7;
	logic [14:0]      prod_s7;
	logic [3:0][7:0]  ch_s8;

	logic [25:0]      wsum;
	logic [2:0][41:0] tsum;
	logic [2:0][40:0] qprod;
	logic [2:0][23:0] rem;
	logic [2:0][7:0]  c_nx;
	logic [7:0]       mn;
	logic [6:0]       share;
	logic [27:0]      wprod;
	logic [7:0]       w;
	logic [3:0][7:0]  ch_nx;

	// Classify: off-strip requests are taken and dropped at once
	assign s_tready = inflight_q < QCW'(QDEPTH);
	assign accept   = s_tvalid && s_tready;
	assign len      = (11'(cfg.strip_length) > 11'(MAX_PIXELS)) ? 11'(MAX_PIXELS)
	                                                             : 11'(cfg.strip_length);
	assign on_strip = 11'(s_tdata[7:0]) < len;
	assign level_x  = 17'(s_tdata[42:32]);
	assign lv       = (level_x > 17'(FULL)) ? LVW'(FULL) : LVW'(level_x);
	assign off      = cfg.four_channel ? {s_tdata[7:0], 4'b0000}
	                                   : 12'({s_tdata[7:0], 3'b000}) + 12'({s_tdata[7:0], 2'b00});
	assign bal      = {cfg.balance_blue, cfg.balance_red, cfg.balance_green};
	assign share    = (cfg.white_share > SHARE_MAX) ? SHARE_MAX : cfg.white_share;

	// Reserve one queue slot per pixel in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({accept && on_strip, pop})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= accept && on_strip;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_comb begin
		wsum = 26'(wg_s2) + WHITE_BIAS;
		mn = c_s6[0];
		if (c_s6[1] < mn) begin
			mn = c_s6[1];
		end
		if (c_s6[2] < mn) begin
			mn = c_s6[2];
		end
		for (int c = 0; c < 3; c++) begin
			tsum[c]  = 42'(p_s3[c]) + ROUND_BIAS;
			qprod[c] = 41'(t_s4[c]) * 41'(RECIP_MUL);
			rem[c]   = t_s5[c] - 24'(q_s5[c]) * BAL_DEN;
			c_nx[c]  = (rem[c] >= BAL_DEN) ? q_s5[c] + 8'd1 : q_s5[c];
		end
		wprod = 28'(prod_s7) * 28'(DIV100_MUL);
		w     = wprod[26:19];
		ch_nx = '0;
		if (meta_s7.func == FUNC_WHITE) begin
			ch_nx[3] = meta_s7.four ? white_s7 : 8'd0;
		end else if (meta_s7.four) begin
			for (int c = 0; c < 3; c++) begin
				ch_nx[c] = c_s7[c] - w;
			end
			ch_nx[3] = w;
		end else begin
			for (int c = 0; c < 3; c++) begin
				ch_nx[c] = c_s7[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: capture request, read gamma ROM
		meta_s1.func     <= s_tuser;
		meta_s1.four     <= cfg.four_channel;
		meta_s1.base_off <= off;
		base_s1          <= {s_tdata[31:24], s_tdata[15:8], s_tdata[23:16]};
		gq_s1            <= gamma_rom[lv];
		// Stage 2: base * gamma, brightness * balance
		for (int c = 0; c < 3; c++) begin
			rg_s2[c] <= 25'(base_s1[c]) * 25'(gq_s1);
			bb_s2[c] <= 16'(cfg.brightness_cap) * 16'(bal[c]);
		end
		wg_s2   <= 25'(gq_s1) * 25'(cfg.brightness_cap);
		meta_s2 <= meta_s1;
		// Stage 3: full product
		for (int c = 0; c < 3; c++) begin
			p_s3[c] <= 41'(rg_s2[c]) * 41'(bb_s2[c]);
		end
		white_s3 <= wsum[23:16];
		meta_s3  <= meta_s2;
		// Stage 4: round and drop the power-of-two part of the divisor
		for (int c = 0; c < 3; c++) begin
			t_s4[c] <= tsum[c][39:16];
		end
		white_s4 <= white_s3;
		meta_s4  <= meta_s3;
		// Stage 5: reciprocal estimate of t / 65025
		for (int c = 0; c < 3; c++) begin
			q_s5[c] <= qprod[c][39:32];
		end
		t_s5     <= t_s4;
		white_s5 <= white_s4;
		meta_s5  <= meta_s4;
		// Stage 6: correct the estimate
		c_s6     <= c_nx;
		white_s6 <= white_s5;
		meta_s6  <= meta_s5;
		// Stage 7: achromatic share
		prod_s7  <= 15'(mn) * 15'(share);
		c_s7     <= c_s6;
		white_s7 <= white_s6;
		meta_s7  <= meta_s6;
		// Stage 8: white split
		ch_s8    <= ch_nx;
		meta_s8  <= meta_s7;
	end

	assign push_valid         = v_s8;
	assign push_data.four     = meta_s8.four;
	assign push_data.base_off = meta_s8.base_off;
	assign push_data.ch       = ch_s8;

endmodule

@@ design/rpse_queue.sv @@
module rpse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rpse_pkg::pix_t push_data,
	input  logic           pop,
	output logic           head_valid,
	output rpse_pkg::pix_t head
);
	import rpse_pkg::*;

	pix_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;

	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ design/rpse_back.sv @@
module rpse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rpse_pkg::pix_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [23:0]    m_tdata,
	output logic           m_tlast
);
	import rpse_pkg::*;

	logic [3:0]  k_q;
	logic        m_tvalid_q;
	logic [7:0]  byte_q;
	logic [11:0] off_q;
	logic        last_q;
	logic        advance;
	logic        is_last;
	logic [7:0]  v;
	logic [1:0]  i;

	assign advance = !m_tvalid_q || m_tready;
	assign is_last = k_q == (head.four ? 4'd15 : 4'd11);
	assign pop     = advance && head_valid && is_last;
	assign v       = head.ch[k_q[3:2]];
	assign i       = k_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= head_valid;
			if (head_valid) begin
				k_q <= is_last ? 4'd0 : k_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			byte_q <= spi_pair(v[{~i, 1'b1}], v[{~i, 1'b0}]);
			off_q  <= head.base_off + 12'(k_q);
			last_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, off_q, byte_q};
	assign m_tlast  = last_q;

endmodule
